FILE: design/tbbq_pkg.sv
// Shared constants, types and arithmetic helpers for the three-band equalizer.
package tbbq_pkg;

    localparam int SampleW = 24;
    localparam int StateW  = 40;
    localparam int CoefW   = 20;
    localparam int CoefFrac = 17;
    localparam int GainW   = 18;
    localparam int GainFrac = 16;
    localparam int RegW    = 60;
    localparam int NumRegs = 7;
    localparam int IdxW    = 3;
    localparam int ProdW   = StateW + CoefW + 1;
    localparam int AccW    = StateW + 4;

    localparam logic [IdxW-1:0] REG_GAINS = 3'd6;
    localparam logic [53:0] GAIN_RESET = 54'h10000_4000_10000;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RD,
        ST_P,
        ST_Y,
        ST_B1,
        ST_B2,
        ST_WB,
        ST_GB,
        ST_GM,
        ST_GT,
        ST_SUM,
        ST_OUT
    } seq_t;

    function automatic logic signed [StateW-1:0] sat_state(input logic signed [AccW-1:0] v);
        logic signed [AccW-1:0] hi;
        logic signed [AccW-1:0] lo;
        hi = AccW'((64'sd1 <<< (StateW-1)) - 1);
        lo = -hi - 1;
        if (v > hi) return hi[StateW-1:0];
        else if (v < lo) return lo[StateW-1:0];
        else return v[StateW-1:0];
    endfunction

endpackage

FILE: design/three_band_biquad_crossover_eq.sv
// Top level of the three-band cascaded biquad equalizer.
// One 24-bit sample word in, one equalized 24-bit word out. Each word runs
// through three crossover stages, each two DF2T lowpass biquads, then a
// gain-weighted sum of treble, mid and bass. A single multiply unit (one
// 40x20 signed product per cycle, rounded and registered) does all work in
// sequence: per biquad the read, x*a0, y, y*b1, y*b2 and write-back steps,
// then per stage the band sum (bass, mid and treble gain steps, then the
// sum), and after the last stage the output register is loaded. The next
// word is taken only once the sequencer is back in idle, so a new word is
// not accepted before the last one is through. The output register keeps
// the input open while a result waits; only when a new result is done
// before the old one is taken does the sequencer hold in its final step.
// The twelve filter states live in a 6-entry synchronous memory (s1/s2
// pair per biquad, registered read); entries are marked by valid bits
// cleared at reset, so no clearing pass is needed. Configuration is accepted
// only while the sequencer is idle.
module three_band_biquad_crossover_eq (
    input  logic clk,
    input  logic rst_n,
    input  logic s_axis_tvalid,
    output logic s_axis_tready,
    input  logic [tbbq_pkg::SampleW-1:0] s_axis_tdata,   // sample_in[23:0]
    output logic m_axis_tvalid,
    input  logic m_axis_tready,
    output logic [tbbq_pkg::SampleW-1:0] m_axis_tdata,   // sample_out[23:0]
    input  logic cfg_valid,
    output logic cfg_ready,
    input  logic [tbbq_pkg::IdxW-1:0] cfg_index,
    input  logic [tbbq_pkg::RegW-1:0] cfg_data
);
    import tbbq_pkg::*;

    logic [RegW-1:0] coef_reg [6];
    logic [3*GainW-1:0] gain_reg;
    logic [2*StateW-1:0] mem [6];
    logic [5:0] vld_reg;
    logic [2*StateW-1:0] rd_reg;

    seq_t state_reg, state_next;
    logic [2:0] bq_reg, bq_next;          // biquad number 0..5
    logic signed [StateW-1:0] x_reg, x_next;   // stage input
    logic signed [StateW-1:0] in_reg, in_next; // current biquad input
    logic signed [StateW-1:0] yh_reg, yh_next;
    logic signed [StateW-1:0] y_reg, y_next;
    logic signed [StateW-1:0] s1_reg, s1_next, s2_reg, s2_next;
    logic signed [StateW-1:0] t_reg, t_next, m_reg, m_next, b_reg, b_next;
    logic signed [AccW-1:0] p_reg, p_next;     // x*a0, not saturated
    logic signed [AccW-1:0] acc_reg, acc_next;
    logic signed [AccW-1:0] prod_reg;
    logic [SampleW-1:0] out_reg, out_next;
    logic ov_reg, ov_next;

    // multiplier operand select
    logic signed [StateW-1:0] mx;
    logic signed [CoefW-1:0] mc;
    logic gain_op;
    logic signed [ProdW-1:0] full;
    logic signed [ProdW-1:0] rnd;
    logic [RegW-1:0] cr;
    logic wr_en;
    logic out_free;
    logic signed [StateW-1:0] rs1, rs2;

    assign cr = coef_reg[bq_reg];
    assign cfg_ready = (state_reg == ST_IDLE);
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = ov_reg;
    assign m_axis_tdata = out_reg;
    assign out_free = !ov_reg || m_axis_tready;
    assign rs1 = vld_reg[bq_reg] ? $signed(rd_reg[StateW-1:0]) : '0;
    assign rs2 = vld_reg[bq_reg] ? $signed(rd_reg[2*StateW-1:StateW]) : '0;

    always_comb
    begin
        mx = in_reg; mc = $signed(cr[19:0]); gain_op = 1'b0;
        unique case (state_reg)
            ST_Y:  begin mx = y_reg; mc = $signed(cr[39:20]); end
            ST_B1: begin mx = y_reg; mc = $signed(cr[59:40]); end
            ST_GB: begin mx = b_reg; mc = $signed({2'b0, gain_reg[53:36]}); gain_op = 1'b1; end
            ST_GM: begin mx = m_reg; mc = $signed({2'b0, gain_reg[35:18]}); gain_op = 1'b1; end
            ST_GT: begin mx = t_reg; mc = $signed({2'b0, gain_reg[17:0]}); gain_op = 1'b1; end
            default: ;
        endcase
        // gains use 18 bits unsigned, fit in 20-bit signed operand
        full = ProdW'(mx) * ProdW'(mc);
        // round to nearest, ties up
        if (gain_op)
            rnd = (full + (ProdW'(1) <<< (GainFrac - 1))) >>> GainFrac;
        else
            rnd = (full + (ProdW'(1) <<< (CoefFrac - 1))) >>> CoefFrac;
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= rnd[AccW-1:0];
        rd_reg <= mem[bq_reg];
        if (wr_en)
            mem[bq_reg] <= {s2_reg, s1_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE; bq_reg <= '0; ov_reg <= 1'b0; vld_reg <= '0;
            for (int i = 0; i < 6; i++) coef_reg[i] <= '0;
            gain_reg <= GAIN_RESET;
        end
        else
        begin
            state_reg <= state_next; bq_reg <= bq_next; ov_reg <= ov_next;
            if (wr_en) vld_reg[bq_reg] <= 1'b1;
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == REG_GAINS) gain_reg <= cfg_data[53:0];
                else if (cfg_index < REG_GAINS) coef_reg[cfg_index] <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg <= x_next; in_reg <= in_next; yh_reg <= yh_next; p_reg <= p_next;
        y_reg <= y_next; s1_reg <= s1_next; s2_reg <= s2_next; t_reg <= t_next;
        m_reg <= m_next; b_reg <= b_next; acc_reg <= acc_next; out_reg <= out_next;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (s_axis_tvalid) state_next = ST_RD;
            ST_RD:   state_next = ST_P;
            ST_P:    state_next = ST_Y;
            ST_Y:    state_next = ST_B1;
            ST_B1:   state_next = ST_B2;
            ST_B2:   state_next = ST_WB;
            ST_WB:   state_next = bq_reg[0] ? ST_GB : ST_RD;
            ST_GB:   state_next = ST_GM;
            ST_GM:   state_next = ST_GT;
            ST_GT:   state_next = ST_SUM;
            ST_SUM:  state_next = (bq_reg == 3'd5) ? ST_OUT : ST_RD;
            ST_OUT:  if (out_free) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // datapath: each state's product appears in prod_reg the next state
    always_comb
    begin
        bq_next = bq_reg; x_next = x_reg; in_next = in_reg; yh_next = yh_reg;
        p_next = p_reg; y_next = y_reg; s1_next = s1_reg; s2_next = s2_reg;
        t_next = t_reg; m_next = m_reg; b_next = b_reg; acc_next = acc_reg;
        out_next = out_reg; ov_next = ov_reg; wr_en = 1'b0;
        if (m_axis_tready) ov_next = 1'b0;
        unique case (state_reg)
            ST_IDLE:
                if (s_axis_tvalid)
                begin
                    x_next = StateW'($signed(s_axis_tdata));
                    in_next = StateW'($signed(s_axis_tdata));
                    bq_next = '0;
                end
            ST_P:
            begin
                // state pair of this biquad is in rd_reg now
                p_next = prod_reg;
                y_next = sat_state(prod_reg + AccW'(rs1));
                s2_next = rs2;
            end
            ST_B1:
                s1_next = sat_state((p_reg <<< 1) - prod_reg + AccW'(s2_reg));
            ST_B2:
                s2_next = sat_state(p_reg - prod_reg);
            ST_WB:
            begin
                wr_en = 1'b1;
                if (!bq_reg[0])
                begin
                    // high split done: treble out, y feeds the low split
                    yh_next = y_reg;
                    t_next = sat_state(AccW'(x_reg) - AccW'(y_reg));
                    in_next = y_reg;
                    bq_next = bq_reg + 3'd1;
                end
                else
                begin
                    b_next = y_reg;
                    m_next = sat_state(AccW'(yh_reg) - AccW'(y_reg));
                end
            end
            ST_GM: acc_next = prod_reg;
            ST_GT: acc_next = acc_reg + prod_reg;
            ST_SUM:
            begin
                x_next = sat_state(acc_reg + prod_reg);
                in_next = sat_state(acc_reg + prod_reg);
                if (bq_reg != 3'd5) bq_next = bq_reg + 3'd1;
            end
            ST_OUT:
                if (out_free)
                begin
                    if (x_reg > 40'sh7FFFFF) out_next = 24'h7FFFFF;
                    else if (x_reg < -40'sh800000) out_next = 24'h800000;
                    else out_next = x_reg[SampleW-1:0];
                    ov_next = 1'b1;
                end
            default: ;
        endcase
    end

    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tready |-> state_reg == ST_IDLE)
        else $error("ready outside idle");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid)
        else $error("result dropped");
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata))
        else $error("result changed while waiting");
    a_last_bq: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_OUT) |-> bq_reg == 3'd5)
        else $error("output before last stage");
endmodule
